// File: hdl/programmable_interval_timer_unit_assert.svh
// Assertion macros for the interval timer checker
`ifndef PROGRAMMABLE_INTERVAL_TIMER_UNIT_ASSERT_SVH
`define PROGRAMMABLE_INTERVAL_TIMER_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PIT_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// implication checked in the following cycle
`define PIT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: hdl/pit_pkg.sv
// ----------------------------------------------------------------------------
// pit_pkg
// Shared types and constants of the interval timer.
// ----------------------------------------------------------------------------
package pit_pkg;
    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_GATE  = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;
    localparam logic [1:0] CTRL_PORT = 2'd3;
    localparam logic [1:0] FMT_LSB   = 2'd1;
    localparam logic [1:0] FMT_MSB   = 2'd2;
    localparam logic [1:0] FMT_BOTH  = 2'd3;
    localparam logic [2:0] MODE_0    = 3'd0;
    localparam logic [2:0] MODE_1    = 3'd1;
    localparam logic [2:0] MODE_2    = 3'd2;
    localparam logic [5:0] CTRL_RESET = 6'h30;
    localparam logic [7:0] BYTE_NONE  = 8'hff;

    // operation broadcast from the decoder to one or more lanes
    typedef struct packed {
        logic       rd;       // data port read
        logic       wr;       // data port write
        logic       ctl;      // control word for this lane
        logic       latch;    // counter latch command
        logic       rb_cnt;   // read-back count latch
        logic       rb_sts;   // read-back status latch
        logic       gate;     // gate change
        logic       tick;     // clock edge
        logic       gate_lvl;
        logic [7:0] data;
    } lane_op_t;

    function automatic logic [2:0] eff_mode(input logic [5:0] cb);
        logic [2:0] m;
        m = cb[3:1];
        if (m[2] && m[1]) m = {1'b0, m[1:0]};
        return m;
    endfunction
endpackage

// File: hdl/programmable_interval_timer_unit.sv
// ----------------------------------------------------------------------------
// programmable_interval_timer_unit
// Three-counter interval timer behind four byte ports, one transfer a cycle unless the result stalls.
// ----------------------------------------------------------------------------
// Each input transfer (port read, port write, gate change or clock tick) is
// decoded into one operation per counter lane; all lanes update in the same
// cycle and a merge stage picks the read byte and packs the output lines
// into the result register. A new item is taken each cycle whenever the
// result register is empty or being drained. Modes 0, 1 and 2 are supported;
// modes 3 to 5 hold the count. Counting is binary only, and the null-count
// status bit always reads 0.
module programmable_interval_timer_unit #(
    parameter int NUM_COUNTERS = 3
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [1:0] s_port,
    input  logic [7:0] s_wdata,
    input  logic [1:0] s_counter_sel,
    input  logic       s_gate_level,
    input  logic [2:0] s_tick_mask,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_rdata,
    output logic [2:0] m_out_levels
);
    import pit_pkg::*;

    logic                    accept;
    lane_op_t                ops [NUM_COUNTERS];
    logic [7:0]              rbytes [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] lvls;
    logic [7:0]              rdata_c;
    logic [2:0]              lv_c;
    logic                    vld_reg, vld_next;
    logic [7:0]              rdata_reg;
    logic [2:0]              lv_reg;

    // output register frees in the same cycle it is drained
    assign s_ready = !vld_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // per-lane decode of the transfer
    always_comb begin
        for (int i = 0; i < NUM_COUNTERS; i++) begin
            ops[i].rd       = (s_req_type == REQ_READ) && (s_port == 2'(i));
            ops[i].wr       = (s_req_type == REQ_WRITE) && (s_port == 2'(i));
            ops[i].ctl      = (s_req_type == REQ_WRITE) && (s_port == CTRL_PORT)
                              && (s_wdata[7:6] == 2'(i)) && (s_wdata[5:4] != 2'd0);
            ops[i].latch    = (s_req_type == REQ_WRITE) && (s_port == CTRL_PORT)
                              && (s_wdata[7:6] == 2'(i)) && (s_wdata[5:4] == 2'd0);
            ops[i].rb_cnt   = (s_req_type == REQ_WRITE) && (s_port == CTRL_PORT)
                              && (s_wdata[7:6] == 2'd3) && s_wdata[i+1] && !s_wdata[5];
            ops[i].rb_sts   = (s_req_type == REQ_WRITE) && (s_port == CTRL_PORT)
                              && (s_wdata[7:6] == 2'd3) && s_wdata[i+1] && !s_wdata[4];
            ops[i].gate     = (s_req_type == REQ_GATE) && (s_counter_sel == 2'(i));
            ops[i].tick     = (s_req_type == REQ_TICK) && s_tick_mask[i];
            ops[i].gate_lvl = s_gate_level;
            ops[i].data     = s_wdata;
        end
    end

    for (genvar g = 0; g < NUM_COUNTERS; g++) begin : g_lane
        pit_lane u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .op_valid  (accept),
            .op        (ops[g]),
            .rd_byte   (rbytes[g]),
            .out_level (lvls[g])
        );
    end

    // merge: absent counters and the control port read as all ones
    always_comb begin
        rdata_c = 8'h00;
        if (s_req_type == REQ_READ) begin
            rdata_c = BYTE_NONE;
            for (int i = 0; i < NUM_COUNTERS; i++)
                if (s_port == 2'(i)) rdata_c = rbytes[i];
        end
        lv_c = 3'd0;
        for (int i = 0; i < NUM_COUNTERS; i++) lv_c[i] = lvls[i];
    end

    assign vld_next = accept ? 1'b1 : (m_ready ? 1'b0 : vld_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= 1'b0;
        else vld_reg <= vld_next;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rdata_reg <= rdata_c;
            lv_reg    <= lv_c;
        end
    end

    assign m_valid      = vld_reg;
    assign m_rdata      = rdata_reg;
    assign m_out_levels = lv_reg;
endmodule

// File: hdl/pit_lane.sv
// ----------------------------------------------------------------------------
// pit_lane
// One 16-bit down counter with its access, latch and output logic.
// ----------------------------------------------------------------------------
module pit_lane (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              op_valid,
    input  pit_pkg::lane_op_t op,
    output logic [7:0]        rd_byte,
    output logic              out_level
);
    import pit_pkg::*;

    logic [15:0] cnt_reg, cnt_next, rld_reg, rld_next, lcnt_reg, lcnt_next;
    logic [5:0]  cb_reg, cb_next;
    logic [7:0]  lo_reg, lo_next, lsts_reg, lsts_next, rd_c;
    logic        wh_reg, wh_next, rh_reg, rh_next, cl_reg, cl_next;
    logic        sl_reg, sl_next, out_reg, out_next, gate_reg, gate_next;
    logic        arm_reg, arm_next, en_reg, en_next;
    logic [2:0]  mode, nmode;
    logic [15:0] dsel, dec, ldv;
    logic        do_load;

    assign mode = eff_mode(cb_reg);
    assign dsel = cl_reg ? lcnt_reg : cnt_reg;
    assign dec  = cnt_reg - 16'd1;

    always_comb begin
        cnt_next = cnt_reg; rld_next = rld_reg; lcnt_next = lcnt_reg;
        cb_next = cb_reg; lo_next = lo_reg; lsts_next = lsts_reg;
        wh_next = wh_reg; rh_next = rh_reg; cl_next = cl_reg; sl_next = sl_reg;
        out_next = out_reg; gate_next = gate_reg; arm_next = arm_reg;
        en_next = en_reg; rd_c = 8'h00; do_load = 1'b0; ldv = rld_reg;
        nmode = eff_mode(op.data[5:0]);
        if (op_valid) begin
            if (op.rd) begin
                if (sl_reg) begin
                    sl_next = 1'b0;
                    rd_c = lsts_reg;
                end else begin
                    case (cb_reg[5:4])
                        FMT_MSB: begin
                            cl_next = 1'b0;
                            rd_c = dsel[15:8];
                        end
                        FMT_BOTH: begin
                            if (!rh_reg) begin
                                rh_next = 1'b1;
                                rd_c = dsel[7:0];
                            end else begin
                                rh_next = 1'b0;
                                cl_next = 1'b0;
                                rd_c = dsel[15:8];
                            end
                        end
                        default: begin
                            cl_next = 1'b0;
                            rd_c = dsel[7:0];
                        end
                    endcase
                end
            end
            if (op.wr) begin
                case (cb_reg[5:4])
                    FMT_MSB: begin
                        do_load = 1'b1;
                        ldv = {op.data, rld_reg[7:0]};
                    end
                    FMT_BOTH: begin
                        if (!wh_reg) begin
                            wh_next = 1'b1;
                            lo_next = op.data;
                            if (mode == MODE_0) en_next = 1'b0;
                        end else begin
                            wh_next = 1'b0;
                            en_next = 1'b1;
                            do_load = 1'b1;
                            ldv = {op.data, lo_reg};
                        end
                    end
                    default: begin
                        do_load = 1'b1;
                        ldv = {rld_reg[15:8], op.data};
                    end
                endcase
                if (do_load) begin
                    rld_next = ldv;
                    arm_next = 1'b1;
                    if (mode == MODE_0) begin
                        cnt_next = ldv;
                        out_next = 1'b0;
                    end
                end
            end
            if (op.rb_sts && !sl_reg) begin
                sl_next = 1'b1;
                lsts_next = {out_reg, 1'b0, cb_reg};
            end
            if ((op.latch || op.rb_cnt) && !cl_reg) begin
                cl_next = 1'b1;
                rh_next = 1'b0;
                lcnt_next = cnt_reg;
            end
            if (op.ctl) begin
                cb_next = op.data[5:0];
                wh_next = 1'b0;
                en_next = 1'b1;
                arm_next = 1'b0;
                if (nmode == MODE_0) out_next = 1'b0;
                else if (nmode == MODE_1 || nmode == MODE_2) out_next = 1'b1;
            end
            if (op.gate && gate_reg != op.gate_lvl) begin
                gate_next = op.gate_lvl;
                if (mode == MODE_1) begin
                    if (op.gate_lvl && arm_reg) begin
                        cnt_next = rld_reg;
                        out_next = 1'b0;
                    end
                end else if (mode == MODE_2) begin
                    if (op.gate_lvl) cnt_next = rld_reg;
                    else out_next = 1'b1;
                end
            end
            if (op.tick) begin
                case (mode)
                    MODE_0: begin
                        if (gate_reg && en_reg) begin
                            if (cnt_reg == 16'd0 && arm_reg) begin
                                out_next = 1'b1;
                                arm_next = 1'b0;
                            end
                            cnt_next = dec;
                        end
                    end
                    MODE_1: begin
                        if (cnt_reg == 16'd0) out_next = 1'b1;
                        cnt_next = dec;
                    end
                    MODE_2: begin
                        if (gate_reg) begin
                            if (arm_reg && cnt_reg[15:1] == 15'd0) begin
                                cnt_next = rld_reg;
                                out_next = 1'b1;
                            end else begin
                                cnt_next = dec;
                                if (arm_reg && dec == 16'd1) out_next = 1'b0;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0; rld_reg <= '0; lcnt_reg <= '0; cb_reg <= CTRL_RESET;
            lo_reg <= '0; lsts_reg <= '0; wh_reg <= 1'b0; rh_reg <= 1'b0;
            cl_reg <= 1'b0; sl_reg <= 1'b0; out_reg <= 1'b0; gate_reg <= 1'b0;
            arm_reg <= 1'b0; en_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next; rld_reg <= rld_next; lcnt_reg <= lcnt_next;
            cb_reg <= cb_next; lo_reg <= lo_next; lsts_reg <= lsts_next;
            wh_reg <= wh_next; rh_reg <= rh_next; cl_reg <= cl_next;
            sl_reg <= sl_next; out_reg <= out_next; gate_reg <= gate_next;
            arm_reg <= arm_next; en_reg <= en_next;
        end
    end

    assign rd_byte   = rd_c;
    assign out_level = out_next;
endmodule

// File: hdl/pit_checker.sv
// ----------------------------------------------------------------------------
// pit_checker
// Port-level checks on the interval timer input and result channels.
// ----------------------------------------------------------------------------
`include "programmable_interval_timer_unit_assert.svh"
module pit_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic [1:0] s_req_type,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_rdata
);
    import pit_pkg::*;

    `PIT_ASSERT_NEXT(a_result_follows, aclk, aresetn, s_valid && s_ready, m_valid, "no result")
    `PIT_ASSERT_IMPL(a_ready_free, aclk, aresetn, !m_valid, s_ready, "stalled when empty")
    `PIT_ASSERT_NEXT(a_nonread_zero, aclk, aresetn, s_valid && s_ready && s_req_type != REQ_READ,
        m_rdata == 8'h00, "nonzero rdata")
    `PIT_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_rdata),
        "result dropped")
endmodule

bind programmable_interval_timer_unit pit_checker u_pit_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_req_type(s_req_type), .m_valid(m_valid), .m_ready(m_ready), .m_rdata(m_rdata)
);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Interval timer check: directed and random port reads, port writes, gate
// changes and clock ticks, each result compared with an in-bench timer model.
// ----------------------------------------------------------------------------
module tb_top;
    import pit_pkg::*;

    localparam int NCNT      = 3;
    localparam int IDLE_LIMIT = 2000;
    localparam int N_RANDOM  = 430;

    // one input transfer
    typedef struct packed {
        logic [1:0] req_type;
        logic [1:0] port;
        logic [7:0] wdata;
        logic [1:0] counter_sel;
        logic       gate_level;
        logic [2:0] tick_mask;
    } bus_item_t;

    // one result transfer
    typedef struct packed {
        logic [7:0] rdata;
        logic [2:0] out_levels;
    } timer_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_req_type = '0;
    logic [1:0] s_port = '0;
    logic [7:0] s_wdata = '0;
    logic [1:0] s_counter_sel = '0;
    logic s_gate_level = 1'b0;
    logic [2:0] s_tick_mask = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_rdata;
    logic [2:0] m_out_levels;

    programmable_interval_timer_unit #(.NUM_COUNTERS(NCNT)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_req_type(s_req_type), .s_port(s_port), .s_wdata(s_wdata),
        .s_counter_sel(s_counter_sel), .s_gate_level(s_gate_level),
        .s_tick_mask(s_tick_mask),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_rdata(m_rdata), .m_out_levels(m_out_levels)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Timer model state, one entry per counter
    // ------------------------------------------------------------------
    logic [15:0] cnt_q   [NCNT];
    logic [15:0] reload_q[NCNT];
    logic [5:0]  ctrl_q  [NCNT];
    logic        wr_msb_q[NCNT];
    logic        rd_msb_q[NCNT];
    logic [7:0]  lsb_hold[NCNT];
    logic [15:0] cnt_snap[NCNT];
    logic        cnt_snap_v[NCNT];
    logic [7:0]  sts_snap[NCNT];
    logic        sts_snap_v[NCNT];
    logic        out_q   [NCNT];
    logic        gate_q  [NCNT];
    logic        armed_q [NCNT];
    logic        run_q   [NCNT];

    bus_item_t     pending_items[$];
    timer_result_t expected_results[$];
    int  n_errors = 0;
    int  n_checked = 0;
    int  n_reads = 0;
    bit  stim_done = 1'b0;
    bit  calm = 1'b0;      // no idling in the closing stretch
    int  src_idle = 0;
    int  snk_idle = 0;

    function automatic logic [2:0] mode_now(int c);
        logic [2:0] m;
        m = ctrl_q[c][3:1];
        if (m >= 3'd6) m = m - 3'd4;
        return m;
    endfunction

    task automatic timer_reset();
        for (int c = 0; c < NCNT; c++) begin
            cnt_q[c] = '0; reload_q[c] = '0; ctrl_q[c] = CTRL_RESET;
            wr_msb_q[c] = 0; rd_msb_q[c] = 0; lsb_hold[c] = '0;
            cnt_snap[c] = '0; cnt_snap_v[c] = 0; sts_snap[c] = '0;
            sts_snap_v[c] = 0; out_q[c] = 0; gate_q[c] = 0;
            armed_q[c] = 0; run_q[c] = 0;
        end
    endtask

    task automatic load_reload(int c, logic [15:0] v);
        reload_q[c] = v;
        armed_q[c] = 1;
        if (mode_now(c) == MODE_0) begin
            cnt_q[c] = v;
            out_q[c] = 0;
        end
    endtask

    task automatic snap_count(int c);
        if (!cnt_snap_v[c]) begin
            cnt_snap_v[c] = 1; rd_msb_q[c] = 0; cnt_snap[c] = cnt_q[c];
        end
    endtask

    task automatic snap_status(int c);
        if (!sts_snap_v[c]) begin
            sts_snap_v[c] = 1;
            sts_snap[c] = {out_q[c], 1'b0, ctrl_q[c]};
        end
    endtask

    function automatic logic [7:0] read_data_port(int c);
        logic [15:0] d;
        if (sts_snap_v[c]) begin
            sts_snap_v[c] = 0;
            return sts_snap[c];
        end
        d = cnt_snap_v[c] ? cnt_snap[c] : cnt_q[c];
        case (ctrl_q[c][5:4])
            FMT_MSB: begin
                cnt_snap_v[c] = 0;
                return d[15:8];
            end
            FMT_BOTH: begin
                if (!rd_msb_q[c]) begin
                    rd_msb_q[c] = 1;
                    return d[7:0];
                end
                rd_msb_q[c] = 0; cnt_snap_v[c] = 0;
                return d[15:8];
            end
            default: begin
                cnt_snap_v[c] = 0;
                return d[7:0];
            end
        endcase
    endfunction

    task automatic write_data_port(int c, logic [7:0] v);
        case (ctrl_q[c][5:4])
            FMT_MSB: load_reload(c, {v, reload_q[c][7:0]});
            FMT_BOTH: begin
                if (!wr_msb_q[c]) begin
                    wr_msb_q[c] = 1; lsb_hold[c] = v;
                    if (mode_now(c) == MODE_0) run_q[c] = 0;
                end else begin
                    wr_msb_q[c] = 0; run_q[c] = 1;
                    load_reload(c, {v, lsb_hold[c]});
                end
            end
            default: load_reload(c, {reload_q[c][15:8], v});
        endcase
    endtask

    task automatic write_control_word(logic [7:0] v);
        int sel;
        logic [2:0] m;
        sel = v[7:6];
        if (sel == 3) begin
            // read-back: bit 5 low latches count, bit 4 low latches status
            for (int c = 0; c < NCNT; c++)
                if (v[c+1]) begin
                    if (!v[4]) snap_status(c);
                    if (!v[5]) snap_count(c);
                end
            return;
        end
        if (sel >= NCNT) return;
        if (v[5:4] == 2'b00) begin
            snap_count(sel);
            return;
        end
        ctrl_q[sel] = v[5:0];
        wr_msb_q[sel] = 0; run_q[sel] = 1; armed_q[sel] = 0;
        m = mode_now(sel);
        if (m == MODE_0) out_q[sel] = 0;
        else if (m == MODE_1 || m == MODE_2) out_q[sel] = 1;
    endtask

    task automatic change_gate(int c, logic g);
        logic [2:0] m;
        if (gate_q[c] == g) return;
        gate_q[c] = g;
        m = mode_now(c);
        if (m == MODE_1) begin
            if (g && armed_q[c]) begin
                cnt_q[c] = reload_q[c]; out_q[c] = 0;
            end
        end else if (m == MODE_2) begin
            if (g) cnt_q[c] = reload_q[c];
            else out_q[c] = 1;
        end
    endtask

    task automatic clock_counter(int c);
        logic [15:0] v;
        v = cnt_q[c];
        case (mode_now(c))
            MODE_0: if (gate_q[c] && run_q[c]) begin
                if (v == 0 && armed_q[c]) begin
                    out_q[c] = 1; armed_q[c] = 0;
                end
                cnt_q[c] = v - 1'b1;
            end
            MODE_1: begin
                if (v == 0) out_q[c] = 1;
                cnt_q[c] = v - 1'b1;
            end
            MODE_2: if (gate_q[c]) begin
                if (armed_q[c] && v <= 1) begin
                    cnt_q[c] = reload_q[c]; out_q[c] = 1;
                end else begin
                    cnt_q[c] = v - 1'b1;
                    if (armed_q[c] && cnt_q[c] == 1) out_q[c] = 0;
                end
            end
            default: ;
        endcase
    endtask

    // advance the model by one accepted transfer, queue its result
    task automatic predict_timer(bus_item_t it);
        timer_result_t r;
        r = '0;
        case (it.req_type)
            REQ_READ: r.rdata = (it.port < NCNT) ? read_data_port(it.port) : BYTE_NONE;
            REQ_WRITE:
                if (it.port == CTRL_PORT) write_control_word(it.wdata);
                else if (it.port < NCNT) write_data_port(it.port, it.wdata);
            REQ_GATE: if (it.counter_sel < NCNT) change_gate(it.counter_sel, it.gate_level);
            default: for (int c = 0; c < NCNT; c++) if (it.tick_mask[c]) clock_counter(c);
        endcase
        for (int c = 0; c < NCNT; c++) r.out_levels[c] = out_q[c];
        expected_results.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic bus_item_t mk(logic [1:0] rt, logic [1:0] p, logic [7:0] d,
                                     logic [1:0] s, logic g, logic [2:0] tm);
        bus_item_t it;
        it = '{rt, p, d, s, g, tm};
        return it;
    endfunction

    task automatic push_ctrl(logic [7:0] w);
        pending_items.push_back(mk(REQ_WRITE, CTRL_PORT, w, 2'($urandom), 1'($urandom),
                                   3'($urandom)));
    endtask

    task automatic push_data(logic [1:0] p, logic [7:0] w);
        pending_items.push_back(mk(REQ_WRITE, p, w, 2'($urandom), 1'($urandom),
                                   3'($urandom)));
    endtask

    task automatic push_read(logic [1:0] p);
        pending_items.push_back(mk(REQ_READ, p, 8'($urandom), 2'($urandom), 1'($urandom),
                                   3'($urandom)));
    endtask

    // well-formed program/run/read sequence with random content
    task automatic push_sequence();
        int c;
        logic [1:0] fmt;
        logic [2:0] md;
        c = $urandom_range(0, 2);
        fmt = 2'($urandom_range(1, 3));
        md = 3'($urandom_range(0, 7));
        push_ctrl({c[1:0], fmt, md, 1'($urandom)});
        push_data(c[1:0], 8'($urandom_range(0, 6)));
        if (fmt == FMT_BOTH)
            push_data(c[1:0], ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd0);
        pending_items.push_back(mk(REQ_GATE, 2'd0, 8'($urandom), c[1:0],
                                   $urandom_range(0, 4) != 0, 3'd0));
        repeat ($urandom_range(1, 8))
            pending_items.push_back(mk(REQ_TICK, 2'($urandom), 8'($urandom), 2'($urandom),
                                       1'($urandom), 3'($urandom) | (3'b1 << c)));
        case ($urandom_range(0, 2))
            0: push_ctrl({c[1:0], 2'b00, 4'($urandom)});
            1: push_ctrl({2'b11, 2'($urandom), 3'($urandom), 1'b0} | (8'h2 << c));
            default: ;
        endcase
        repeat ($urandom_range(1, 3)) push_read(c[1:0]);
    endtask

    initial begin
        timer_reset();
        // directed: reads of every port, LSB and both-byte formats, latch, read-back,
        // mode codes six and seven, same-level gate, absent counter select
        push_read(0); push_read(3); push_read(1);
        push_ctrl(8'h34);                  // counter 0, both bytes, mode 2
        push_data(0, 8'h02); push_data(0, 8'h00);
        pending_items.push_back(mk(REQ_GATE, 2'd0, 8'd0, 2'd0, 1'b1, 3'd0));
        pending_items.push_back(mk(REQ_GATE, 2'd0, 8'd0, 2'd0, 1'b1, 3'd0));
        pending_items.push_back(mk(REQ_TICK, 2'd0, 8'd0, 2'd0, 1'b0, 3'b111));
        pending_items.push_back(mk(REQ_TICK, 2'd0, 8'd0, 2'd0, 1'b0, 3'b001));
        push_ctrl(8'h5C);                  // counter 1, LSB, mode code six
        push_data(1, 8'hFF);
        push_ctrl(8'h9F);                  // counter 2, LSB, mode code seven, BCD
        push_data(2, 8'h00);
        push_ctrl(8'hC0);                  // read-back of nothing
        push_ctrl(8'hCE);                  // count and status of all
        push_ctrl(8'hCE);                  // repeat keeps the held values
        push_read(0); push_read(0); push_read(0);
        push_ctrl(8'h00);                  // counter latch on counter 0
        push_read(0); push_read(1);
        pending_items.push_back(mk(REQ_GATE, 2'd0, 8'd0, 2'd3, 1'b1, 3'd0));
        push_ctrl(8'hF2);                  // read-back with neither latch
        push_read(2);
        for (int i = 0; i < N_RANDOM;) begin
            if ($urandom_range(0, 9) < 7) begin
                int n;
                n = pending_items.size();
                push_sequence();
                i += pending_items.size() - n;
            end else begin
                pending_items.push_back(bus_item_t'(18'($urandom)));
                i++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: holds valid and payload until the transfer completes
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) predict_timer(pending_items.pop_front());
            if (!s_valid || s_ready) begin
                if (src_idle > 0) begin
                    src_idle <= src_idle - 1;
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    src_idle <= $urandom_range(1, 17) - 1;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    s_valid <= 1'b1;
                    {s_req_type, s_port, s_wdata, s_counter_sel, s_gate_level,
                     s_tick_mask} <= pending_items[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                timer_result_t want;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result rdata=%h out_levels=%b",
                             $realtime, m_rdata, m_out_levels);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    n_checked++;
                    if (m_rdata !== want.rdata) begin
                        $display("%0t: rdata mismatch expected %h actual %h",
                                 $realtime, want.rdata, m_rdata);
                        n_errors++;
                    end
                    if (m_out_levels !== want.out_levels) begin
                        $display("%0t: out_levels mismatch expected %b actual %b",
                                 $realtime, want.out_levels, m_out_levels);
                        n_errors++;
                    end
                end
            end
            // receiver stalls in bursts
            if (snk_idle > 0) begin
                snk_idle <= snk_idle - 1;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                snk_idle <= $urandom_range(1, 17) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Reset, end of run and watchdog
    // ------------------------------------------------------------------
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0) begin
            @(posedge aclk);
            if (pending_items.size() < 60) calm = 1'b1;
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: watchdog, no transfer for %0d cycles", $realtime, IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
        repeat (10) @(posedge aclk);
        if (m_valid) begin
            $display("%0t: result beyond the predicted stream", $realtime);
            n_errors++;
        end
        $display("Checked %0d results from mixed port, gate and tick transfers.", n_checked);
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// File: sim.f
+incdir+hdl
hdl/pit_pkg.sv
hdl/pit_lane.sv
hdl/programmable_interval_timer_unit.sv
hdl/pit_checker.sv
verif/tb_top.sv
